// ===== hw/rtl/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// ccs_pkg: shared types and constants
// Character codes and the result bundle that travels from the front part,
// through the queue, to the back part of the comment splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

   // Characters the splitter reacts to or emits
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NONE    = 8'h00;

   // Up to four results per item
   localparam int RES_MAX = 4;
   localparam int CNT_W   = 3;
   localparam int IDX_W   = 2;

   // Bundle queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // All results caused by one item
   typedef struct packed {
      logic [CNT_W-1:0]          count;
      logic [RES_MAX-1:0][7:0]   bytes;
      logic [RES_MAX-1:0]        comment;
   } bundle_type;

endpackage

`default_nettype wire

// ===== hw/rtl/c_comment_splitter.sv =====
// An item's first result goes through the queue and then the output register before rsp.
// Throughput: one item per cycle while items average at most one result and rsp is not
// stalled; the output register drains one result per cycle while rsp_tready is high.
// A four-entry queue of per-item result bundles lets intake run up to four items ahead.
// Reset: synchronous, active high; clears modes, held byte, queue and output valid.
// ----------------------------------------------------------------------------
// c_comment_splitter: source text splitter into code and comment streams
// Front part classifies bytes with one byte of look-ahead, back part emits.
// ----------------------------------------------------------------------------
`default_nettype none

module c_comment_splitter import ccs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] ch
   input  wire logic       req_tlast,   // end_of_text
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tuser,   // to_comment
   output logic            rsp_tlast    // last_of_run
);

   logic        push;
   bundle_type  push_data;
   logic        full;
   logic        pop;
   bundle_type  head;
   logic        empty;

   ccs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_ch     (req_tdata),
      .in_last   (req_tlast),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   ccs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   ccs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (rsp_tdata),
      .out_comment (rsp_tuser),
      .out_last    (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/ccs_front.sv =====
// ----------------------------------------------------------------------------
// ccs_front: item intake and classification
// Holds one byte back, judges it against the incoming byte, tracks the
// comment modes and builds the bundle of results for each item.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_front import ccs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [7:0] in_ch,
   input  wire logic       in_last,
   output logic            push,
   output bundle_type      push_data,
   input  wire logic       full
);

   // Outcome of judging one byte with its look-ahead
   typedef struct packed {
      logic [1:0]       n;
      logic [2:0][7:0]  b;
      logic [2:0]       cm;
      logic             line;
      logic             block;
      logic             skip;
   } judge_type;

   function automatic judge_type judge(input logic [7:0] c, input logic [7:0] la,
                                       input logic line, input logic block);
      judge_type r;
      r       = '0;
      r.line  = line;
      r.block = block;
      priority if (c == CHAR_SLASH && la == CHAR_SLASH) begin
         r.line = 1'b1;
      end else if (c == CHAR_SLASH && la == CHAR_STAR) begin
         r.block = 1'b1;
      end else if (line && c == CHAR_NEWLINE) begin
         r.line  = 1'b0;
         r.n     = 2'd2;
         r.b[0]  = CHAR_NEWLINE;
         r.cm[0] = 1'b1;
         r.b[1]  = CHAR_NEWLINE;
         r.cm[1] = 1'b0;
      end else if (block && c == CHAR_STAR && la == CHAR_SLASH) begin
         r.block = 1'b0;
         r.skip  = 1'b1;
         r.n     = 2'd3;
         r.b[0]  = CHAR_NEWLINE;
         r.cm[0] = 1'b1;
         r.b[1]  = CHAR_SPACE;
         r.cm[1] = 1'b1;
         r.b[2]  = CHAR_NEWLINE;
         r.cm[2] = 1'b0;
      end else if (block || line) begin
         if (c != CHAR_SLASH && c != CHAR_STAR) begin
            r.n     = 2'd1;
            r.b[0]  = c;
            r.cm[0] = 1'b1;
         end
      end else begin
         r.n     = 2'd1;
         r.b[0]  = c;
         r.cm[0] = 1'b0;
      end
      return r;
   endfunction

   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_valid_ff, held_valid_in;
   logic        line_ff, line_in;
   logic        block_ff, block_in;
   logic        accept;
   judge_type   first_j;
   judge_type   second_j;
   logic        second_en;
   bundle_type  bundle;

   assign in_ready = !full;
   assign accept   = in_valid && !full;

   // Held byte against the new byte, then the new byte at end of text
   always_comb begin
      if (held_valid_ff) begin
         first_j = judge(held_byte_ff, in_ch, line_ff, block_ff);
      end else begin
         first_j       = '0;
         first_j.line  = line_ff;
         first_j.block = block_ff;
      end
      second_en = in_last && !first_j.skip;
      if (second_en) begin
         second_j = judge(in_ch, CHAR_NONE, first_j.line, first_j.block);
      end else begin
         second_j = '0;
      end
   end

   // Pack both outcomes into one bundle, second after first
   always_comb begin
      bundle       = '0;
      bundle.count = {1'b0, first_j.n} + {1'b0, second_j.n};
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < first_j.n) begin
            bundle.bytes[i]   = first_j.b[i];
            bundle.comment[i] = first_j.cm[i];
         end
      end
      for (int i = 0; i < RES_MAX; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (2'(j) < second_j.n && ({1'b0, first_j.n} + CNT_W'(j)) == CNT_W'(i)) begin
               bundle.bytes[i]   = second_j.b[j];
               bundle.comment[i] = second_j.cm[j];
            end
         end
      end
   end

   assign push      = accept && (bundle.count != '0);
   assign push_data = bundle;

   // Mode and held byte update
   always_comb begin
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      line_in       = line_ff;
      block_in      = block_ff;
      if (accept) begin
         if (in_last) begin
            held_byte_in  = '0;
            held_valid_in = 1'b0;
            line_in       = 1'b0;
            block_in      = 1'b0;
         end else begin
            line_in  = first_j.line;
            block_in = first_j.block;
            if (first_j.skip) begin
               held_byte_in  = '0;
               held_valid_in = 1'b0;
            end else begin
               held_byte_in  = in_ch;
               held_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
         line_ff       <= 1'b0;
         block_ff      <= 1'b0;
      end else begin
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         line_ff       <= line_in;
         block_ff      <= block_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ccs_queue.sv =====
// ----------------------------------------------------------------------------
// ccs_queue: bundle queue
// Short first-in first-out queue of result bundles between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_queue import ccs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire bundle_type push_data,
   output logic            full,
   input  wire logic       pop,
   output bundle_type      head,
   output logic            empty
);

   bundle_type              store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = store_ff[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ccs_back.sv =====
// ----------------------------------------------------------------------------
// ccs_back: result serializer
// Walks the head bundle one result per cycle into the output register, unless out_ready stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_back import ccs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire bundle_type head,
   input  wire logic       empty,
   output logic            pop,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [7:0]      out_byte,
   output logic            out_comment,
   output logic            out_last
);

   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             comment_ff, comment_in;
   logic             last_ff, last_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             load;
   logic             slot_last;

   assign load      = !empty && (!valid_ff || out_ready);
   assign slot_last = ({1'b0, idx_ff} + CNT_W'(1)) == head.count;
   assign pop       = load && slot_last;

   // Next output item and slot index
   always_comb begin
      valid_in   = valid_ff;
      byte_in    = byte_ff;
      comment_in = comment_ff;
      last_in    = last_ff;
      idx_in     = idx_ff;
      if (load) begin
         valid_in   = 1'b1;
         byte_in    = head.bytes[idx_ff];
         comment_in = head.comment[idx_ff];
         last_in    = slot_last;
         idx_in     = slot_last ? '0 : idx_ff + 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      comment_ff <= comment_in;
      last_ff    <= last_in;
   end

   assign out_valid   = valid_ff;
   assign out_byte    = byte_ff;
   assign out_comment = comment_ff;
   assign out_last    = last_ff;

endmodule

`default_nettype wire

// ===== tb/sv/ccs_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ccs_checker: result predictor and scoreboard for the comment splitter
// Watches the req and rsp channels. Every accepted req item is run through a
// local model of the splitter. The results it predicts are queued, and each
// accepted rsp item is compared with the oldest one, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_checker import ccs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] ch
   input  wire logic       req_tlast,   // end_of_text
   input  wire logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire logic [7:0] rsp_tdata,   // [7:0] out_byte
   input  wire logic       rsp_tuser,   // to_comment
   input  wire logic       rsp_tlast,   // last_of_run
   output int              fail_count,
   output int              pending_count
);

   localparam int PRINT_MAX = 40;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       to_comment;
      logic       run_end;
   } text_result_type;

   // Model state of the splitter
   logic [7:0] held_char;
   logic       held_ok;
   logic       consume_next;
   logic       line_mode;
   logic       block_mode;

   text_result_type expected_out[$];
   text_result_type run_buf[$];
   int              mismatches = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < PRINT_MAX)
         $display("ccs_checker: %0t: %s got 0x%02h expected 0x%02h", $realtime, what,
                  got, want);
      mismatches++;
   endtask

   task automatic emit_char(input logic [7:0] b, input logic cm);
      text_result_type r;
      r.out_byte   = b;
      r.to_comment = cm;
      r.run_end    = 1'b0;
      run_buf.push_back(r);
   endtask

   // Judge one byte with its look-ahead
   task automatic judge_char(input logic [7:0] c, input logic [7:0] la);
      if (c == CHAR_SLASH && la == CHAR_SLASH) begin
         line_mode = 1'b1;
      end else if (c == CHAR_SLASH && la == CHAR_STAR) begin
         block_mode = 1'b1;
      end else if (line_mode && c == CHAR_NEWLINE) begin
         line_mode = 1'b0;
         emit_char(CHAR_NEWLINE, 1'b1);
         emit_char(CHAR_NEWLINE, 1'b0);
      end else if (block_mode && c == CHAR_STAR && la == CHAR_SLASH) begin
         block_mode   = 1'b0;
         consume_next = 1'b1;
         emit_char(CHAR_NEWLINE, 1'b1);
         emit_char(CHAR_SPACE, 1'b1);
         emit_char(CHAR_NEWLINE, 1'b0);
      end else if (block_mode || line_mode) begin
         if (c != CHAR_SLASH && c != CHAR_STAR)
            emit_char(c, 1'b1);
      end else begin
         emit_char(c, 1'b0);
      end
   endtask

   task automatic clear_model();
      held_char    = CHAR_NONE;
      held_ok      = 1'b0;
      consume_next = 1'b0;
      line_mode    = 1'b0;
      block_mode   = 1'b0;
   endtask

   // One accepted text byte: predict its results and queue them
   task automatic advance_text(input logic [7:0] c, input logic is_end);
      text_result_type r;
      run_buf.delete();
      consume_next = 1'b0;
      if (held_ok)
         judge_char(held_char, c);
      if (consume_next) begin
         consume_next = 1'b0;
         held_ok      = 1'b0;
         held_char    = CHAR_NONE;
      end else if (is_end) begin
         judge_char(c, CHAR_NONE);
         consume_next = 1'b0;
      end else begin
         held_char = c;
         held_ok   = 1'b1;
      end
      if (is_end)
         clear_model();
      for (int i = 0; i < run_buf.size(); i++) begin
         r = run_buf[i];
         r.run_end = (i == run_buf.size() - 1);
         expected_out.push_back(r);
      end
   endtask

   // Compare one accepted result with the oldest expectation
   task automatic check_result();
      text_result_type want;
      if (expected_out.size() == 0) begin
         report_mismatch("unexpected result, byte", int'(rsp_tdata), 0);
      end else begin
         want = expected_out.pop_front();
         if (rsp_tdata !== want.out_byte)
            report_mismatch("out_byte", int'(rsp_tdata), int'(want.out_byte));
         if (rsp_tuser !== want.to_comment)
            report_mismatch("to_comment", int'(rsp_tuser), int'(want.to_comment));
         if (rsp_tlast !== want.run_end)
            report_mismatch("last_of_run", int'(rsp_tlast), int'(want.run_end));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
         expected_out.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result();
         if (req_tvalid && req_tready)
            advance_text(req_tdata, req_tlast);
      end
      fail_count    <= mismatches;
      pending_count <= expected_out.size();
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for the comment splitter
// Sends short directed texts, then random texts of comment tokens, letters and
// noise, with bursty input and a patterned output stall. The checker
// predicts and compares; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import ccs_pkg::*;;

   localparam int RANDOM_ITEMS = 100;
   localparam int CYCLE_LIMIT  = 60000;
   localparam int DRAIN_CYCLES = 8;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] ch
   logic       req_tlast  = 1'b0;    // end_of_text
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic       rsp_tuser;            // to_comment
   logic       rsp_tlast;            // last_of_run

   int fail_count;
   int pending_count;
   int cycles      = 0;
   int items_sent  = 0;
   int burst_left  = 0;
   int rx_phase    = 0;
   int rx_mode     = 0;

   c_comment_splitter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   ccs_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver stall pattern: mode picked afresh each time rx_phase wraps to zero
   always @(posedge clock) begin
      if (rx_phase == 0)
         rx_mode = $urandom_range(0, 2);
      case (rx_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (rx_phase % 4 == 0);
      endcase
      rx_phase = (rx_phase + 1) % 64;
   end

   // Drive one item and wait for its handshake
   task automatic send_item(input logic [7:0] c, input logic is_end);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= is_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      // bursts of random length, gaps between them
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 7);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], i == s.len() - 1);
   endtask

   // Random text: mostly comment tokens and plain letters, some raw noise
   task automatic send_random_text();
      int         len;
      logic       noise;
      logic [7:0] c;
      len   = $urandom_range(1, 12);
      noise = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
         if (noise) begin
            c = 8'($urandom);
         end else begin
            case ($urandom_range(0, 11))
               0, 1, 2: c = 8'h61 + 8'($urandom_range(0, 25));
               3:       c = CHAR_SPACE;
               4, 5:    c = CHAR_NEWLINE;
               6, 7, 8: c = CHAR_SLASH;
               9, 10:   c = CHAR_STAR;
               default: c = 8'($urandom);
            endcase
         end
         send_item(c, i == len - 1);
      end
   endtask

   initial begin
      int  random_start;
      bit  paused;
      paused = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed texts
      send_text("A");              // end on the first byte, nothing held
      send_text("x//c\n");         // line comment closed by newline
      send_text("/*q*/z");         // block comment, slash consumed
      send_text("/*//\n*/");       // both modes, end byte consumed
      send_item(CHAR_NONE, 1'b0);  // zero byte is ordinary
      send_item(8'hFF, 1'b0);
      send_item(CHAR_STAR, 1'b1);  // look-ahead zero at end of text
      send_text("a*/");            // star-slash outside a comment
      send_text("k//");            // comment opened by the last two bytes

      // Random texts, with one full drain in the middle
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if (!paused && items_sent - random_start >= RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending_count != 0);
         end
         send_random_text();
      end
      req_tvalid <= 1'b0;

      // Drain and verdict
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
